@@ src/kpad_pkg.sv @@
package kpad_pkg;

  // fixed field widths
  localparam int COL_W      = 5;
  localparam int LED_W      = 3;
  localparam int DRIVE_W    = 4;
  localparam int KEY_W      = 5;
  localparam int KEY_CALC_W = 6;
  localparam int CNT_W      = 8;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_MAX_W  = 3;
  localparam int COL_IDX_W  = $clog2(COL_W);

  // front-to-back queue depth
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } cfg_reg_t;

  // input item kinds
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_PIN  = 1'b1
  } item_kind_t;

  // key number multiplier per column bit
  localparam logic [2:0] KEY_MULT [COL_W] = '{3'd0, 3'd3, 3'd2, 3'd1, 3'd4};

  // classified item handed from front to back
  typedef struct packed {
    logic [LED_W-1:0]     led;
    logic [DRIVE_W-1:0]   drive;
    logic [ROW_MAX_W-1:0] row;
    logic [COL_W-1:0]     diff;
    logic [COL_W-1:0]     sample;
  } entry_t;

endpackage

@@ src/kpad_if.sv @@
interface kpad_sample_if;
  import kpad_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [COL_W-1:0] column_sample;
  modport source (output valid, kind, column_sample, input ready);
  modport sink   (input valid, kind, column_sample, output ready);
endinterface

interface kpad_result_if;
  import kpad_pkg::*;
  logic               valid;
  logic               ready;
  logic [LED_W-1:0]   led_pins;
  logic [DRIVE_W-1:0] row_drive;
  logic               event_valid;
  logic [KEY_W-1:0]   key_index;
  logic               key_pressed;
  logic               last;
  modport source (output valid, led_pins, row_drive, event_valid, key_index, key_pressed,
                  last, input ready);
  modport sink   (input valid, led_pins, row_drive, event_valid, key_index, key_pressed,
                  last, output ready);
endinterface

interface kpad_cfg_if;
  import kpad_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DUTY_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/kpad_front.sv @@
module kpad_front #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 5
) (
  input  logic             clk,
  input  logic             rst,
  kpad_sample_if.sink      sample_ch,
  kpad_cfg_if.sink         cfg_ch,
  output logic             push,
  output kpad_pkg::entry_t push_entry,
  input  logic             queue_full
);
  import kpad_pkg::*;

  localparam int ROW_W = $clog2(ROWS);
  localparam logic [COL_W-1:0] COL_MASK = COL_W'((1 << COLUMNS) - 1);

  logic [CNT_W-1:0]  pwm_count;
  logic [ROW_W-1:0]  row_select;
  logic [LED_W-1:0]  led_level;
  logic [DUTY_W-1:0] duty_red;
  logic [DUTY_W-1:0] duty_green;
  logic [DUTY_W-1:0] duty_blue;
  logic [COL_W-1:0]  row_keys [ROWS];

  logic              accept;
  logic              is_tick;
  logic              wrap;
  logic              examine;
  logic [CNT_W-1:0]  pwm_count_next;
  logic [ROW_W-1:0]  row_select_next;
  logic [LED_W-1:0]  led_level_next;
  logic [COL_W-1:0]  sample_m;
  logic [COL_W-1:0]  diff;
  logic [DRIVE_W-1:0] drive;

  assign accept    = sample_ch.valid && !queue_full;
  assign sample_ch.ready = !queue_full;
  assign cfg_ch.ready    = 1'b1;

  // classify the item and work out the next state
  always_comb begin
    is_tick        = (item_kind_t'(sample_ch.kind) == KIND_TICK);
    pwm_count_next = pwm_count + CNT_W'(1);
    wrap           = is_tick && (pwm_count_next == '0);
    if (wrap) begin
      row_select_next = (row_select == ROW_W'(ROWS - 1)) ? '0 : row_select + ROW_W'(1);
    end else begin
      row_select_next = row_select;
    end
    examine  = wrap || !is_tick;
    sample_m = sample_ch.column_sample & COL_MASK;
    diff     = examine ? (sample_m ^ row_keys[row_select_next]) : '0;

    // LED pins clear at the wrap, then set on a duty match
    led_level_next = led_level;
    if (is_tick) begin
      if (wrap) begin
        led_level_next = '0;
      end
      if (pwm_count_next == duty_red)   led_level_next[0] = 1'b1;
      if (pwm_count_next == duty_green) led_level_next[1] = 1'b1;
      if (pwm_count_next == duty_blue)  led_level_next[2] = 1'b1;
    end

    // active-low row drive, rows past the field read as idle
    for (int i = 0; i < DRIVE_W; i++) begin
      drive[i] = (ROW_MAX_W'(row_select_next) != ROW_MAX_W'(i));
    end
  end

  assign push              = accept;
  assign push_entry.led    = led_level_next;
  assign push_entry.drive  = drive;
  assign push_entry.row    = ROW_MAX_W'(row_select_next);
  assign push_entry.diff   = diff;
  assign push_entry.sample = sample_m;

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count  <= '0;
      row_select <= '0;
      led_level  <= '1;
      for (int i = 0; i < ROWS; i++) begin
        row_keys[i] <= '0;
      end
    end else if (accept) begin
      if (is_tick) begin
        pwm_count <= pwm_count_next;
        led_level <= led_level_next;
      end
      row_select <= row_select_next;
      if (examine) begin
        row_keys[row_select_next] <= sample_m;
      end
    end
  end

  // duty registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_red   <= '0;
      duty_green <= '0;
      duty_blue  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_RED:   duty_red   <= cfg_ch.data;
        REG_GREEN: duty_green <= cfg_ch.data;
        REG_BLUE:  duty_blue  <= cfg_ch.data;
        default:   ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_select <= ROW_W'(ROWS - 1))
    else $error("row select out of range");

  a_wrap_moves_row: assert property (@(posedge clk) disable iff (rst)
    (accept && wrap) |=> (row_select != $past(row_select)))
    else $error("counter wrap did not advance the row");
`endif

endmodule

@@ src/kpad_queue.sv @@
module kpad_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kpad_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output kpad_pkg::entry_t head
);
  import kpad_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue overfilled");
`endif

endmodule

@@ src/kpad_back.sv @@
module kpad_back #(
  parameter int ROWS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  kpad_pkg::entry_t head,
  output logic             pop,
  kpad_result_if.source    result_ch
);
  import kpad_pkg::*;

  logic [COL_W-1:0]      served;
  logic                  out_valid;
  logic [COL_W-1:0]      remaining;
  logic [COL_W-1:0]      low_onehot;
  logic [COL_W-1:0]      rest;
  logic [COL_IDX_W-1:0]  low_idx;
  logic [KEY_CALC_W-1:0] key_sum;
  logic                  out_free;
  logic                  emit;
  logic                  is_null;

  // pick the lowest changed column not yet reported
  always_comb begin
    remaining = head.diff & ~served;
    low_idx   = '0;
    for (int i = COL_W - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        low_idx = COL_IDX_W'(i);
      end
    end
    low_onehot = remaining & (~remaining + COL_W'(1));
    rest       = remaining & ~low_onehot;
    is_null    = (remaining == '0);
    key_sum    = KEY_CALC_W'(head.row) + KEY_CALC_W'(KEY_MULT[low_idx]) * KEY_CALC_W'(ROWS);
  end

  assign out_free = !out_valid || result_ch.ready;
  assign emit     = head_valid && out_free;
  assign pop      = emit && (rest == '0);

  assign result_ch.valid = out_valid;

  // output register and per-item progress
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      served    <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        served    <= pop ? '0 : (served | low_onehot);
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      result_ch.led_pins    <= head.led;
      result_ch.row_drive   <= head.drive;
      result_ch.event_valid <= !is_null;
      result_ch.key_index   <= is_null ? '0 : key_sum[KEY_W-1:0];
      result_ch.key_pressed <= is_null ? 1'b0 : head.sample[low_idx];
      result_ch.last        <= (rest == '0);
    end
  end

`ifndef ASSERT_OFF
  a_served_subset: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ((served & ~head.diff) == '0))
    else $error("reported column not in change mask");

  a_served_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (served == '0))
    else $error("progress mask left over without an item");

  a_null_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_ch.event_valid) |-> result_ch.last)
    else $error("no-change result not marked last");
`endif

endmodule

@@ src/keypad_scan_with_led_pwm.sv @@
// The first result of an item passes through the queue and then the output register
// after the item is accepted.
// Throughput: one result per cycle from the output register while the receiver is ready;
// an item gives as many results as it has changed keys, at least one and at most five.
// A two-entry queue lets the front accept items while the back still emits results.
// Reset (rst, synchronous): counter, row, stored keys and duties clear, LED pins go
// all ones, queue and output register empty; ready again the cycle after reset.
module keypad_scan_with_led_pwm #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 5
) (
  input  logic          clk,
  input  logic          rst,
  kpad_sample_if.sink   sample_ch,
  kpad_result_if.source result_ch,
  kpad_cfg_if.sink      cfg_ch
);
  import kpad_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  kpad_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .cfg_ch     (cfg_ch),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  kpad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  kpad_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result_ch  (result_ch)
  );

endmodule

@@ dv/keypad_scan_with_led_pwm_tb.sv @@
`timescale 1ns / 100ps

module keypad_scan_with_led_pwm_tb;
  import kpad_pkg::*;

  // one result as seen on the result channel
  typedef struct packed {
    logic [LED_W-1:0]   led;
    logic [DRIVE_W-1:0] drive;
    logic               ev;
    logic [KEY_W-1:0]   key;
    logic               pressed;
    logic               last;
  } key_event_t;

  // directed stimulus row; want is used only where typed is set
  typedef struct {
    item_kind_t       kind;
    logic [COL_W-1:0] cols;
    bit               to_wrap;
    bit               typed;
    key_event_t       want;
  } scan_row_t;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES      = 6;
  localparam int STEPS       = 6;

  localparam int RED_BIT   = 0;
  localparam int GREEN_BIT = 1;
  localparam int BLUE_BIT  = 2;

  // key number = row + weight * 4
  localparam logic [2:0] COL_WEIGHT [COL_W] = '{3'd0, 3'd3, 3'd2, 3'd1, 3'd4};

  // idle result with all LED pins high
  localparam key_event_t QUIET_ROW0 = {3'b111, 4'b1110, 1'b0, 5'd0, 1'b0, 1'b1};
  localparam key_event_t QUIET_ROW1 = {3'b111, 4'b1101, 1'b0, 5'd0, 1'b0, 1'b1};

  // per-phase idling, percent per cycle
  localparam int SEND_IDLE [PHASES]  = '{0, 68, 0, 19, 0, 68};
  localparam int RECV_STALL [PHASES] = '{0, 0, 68, 19, 0, 68};

  logic clk;
  logic rst;

  kpad_sample_if sample_ch ();
  kpad_result_if result_ch ();
  kpad_cfg_if    cfg_ch ();

  keypad_scan_with_led_pwm dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  // scanner state kept alongside the block
  logic [CNT_W-1:0]  pwm_cnt = '0;
  logic [1:0]        cur_row = '0;
  logic [COL_W-1:0]  keys_held [4] = '{default: '0};
  logic [LED_W-1:0]  led_lvl = '1;
  logic [DUTY_W-1:0] red_at = '0;
  logic [DUTY_W-1:0] green_at = '0;
  logic [DUTY_W-1:0] blue_at = '0;

  key_event_t key_events_due [$];
  key_event_t scan_out [COL_W];
  key_event_t got_event;
  key_event_t want_event;
  int         scan_count;
  int         results_seen;
  int         mismatches;
  int         quiet_cycles;
  bit         moved;

  // handshake between the stimulus and the monitor
  bit         typed_on;
  key_event_t typed_want;
  int         snd_pct;
  int         rcv_pct;
  bit         hold_req;
  int         hold_left;

  scan_row_t directed_rows [17] = '{
    '{KIND_PIN,  5'b00000, 1'b0, 1'b1, QUIET_ROW0},
    '{KIND_PIN,  5'b11111, 1'b0, 1'b0, '0},
    '{KIND_PIN,  5'b11111, 1'b0, 1'b1, QUIET_ROW0},
    '{KIND_PIN,  5'b00000, 1'b0, 1'b0, '0},
    '{KIND_PIN,  5'b10101, 1'b0, 1'b0, '0},
    '{KIND_TICK, 5'b11111, 1'b0, 1'b1, QUIET_ROW0},
    '{KIND_PIN,  5'b01010, 1'b0, 1'b0, '0},
    // first wrap: row 1 untouched, zero duties set all pins again
    '{KIND_TICK, 5'b00000, 1'b1, 1'b1, QUIET_ROW1},
    '{KIND_PIN,  5'b11111, 1'b0, 1'b0, '0},
    '{KIND_TICK, 5'b10000, 1'b0, 1'b0, '0},
    '{KIND_TICK, 5'b01000, 1'b0, 1'b0, '0},
    // plain ticks and key changes on row 1
    '{KIND_TICK, 5'b00000, 1'b0, 1'b0, '0},
    '{KIND_PIN,  5'b01010, 1'b0, 1'b0, '0},
    '{KIND_TICK, 5'b11111, 1'b0, 1'b1, QUIET_ROW1},
    '{KIND_PIN,  5'b00000, 1'b0, 1'b0, '0},
    '{KIND_PIN,  5'b11111, 1'b0, 1'b0, '0},
    '{KIND_PIN,  5'b00001, 1'b0, 1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // advance the scanner by one item, fill scan_out, return its result count
  function automatic int scan_keypad(input item_kind_t kind, input logic [COL_W-1:0] cols);
    logic [COL_W-1:0]   diff;
    logic [DRIVE_W-1:0] drive;
    bit                 do_scan;
    int                 n;
    n = 0;
    if (kind == KIND_TICK) begin
      pwm_cnt = pwm_cnt + 8'd1;
      if (pwm_cnt == '0) begin
        led_lvl = '0;
        cur_row = cur_row + 2'd1;   // four rows, wraps on its own
      end
    end
    do_scan = (kind == KIND_PIN) || (pwm_cnt == '0);
    drive = ~(4'b0001 << cur_row);
    if (do_scan) begin
      diff = cols ^ keys_held[cur_row];
      keys_held[cur_row] = cols;
      for (int b = 0; b < COL_W; b++) begin
        if (diff[b]) begin
          scan_out[n] = {led_lvl, drive, 1'b1,
                         5'(cur_row) + 5'(COL_WEIGHT[b]) * 5'd4, cols[b], 1'b0};
          n++;
        end
      end
    end
    if (kind == KIND_TICK) begin
      if (pwm_cnt == red_at)   led_lvl[RED_BIT]   = 1'b1;
      if (pwm_cnt == green_at) led_lvl[GREEN_BIT] = 1'b1;
      if (pwm_cnt == blue_at)  led_lvl[BLUE_BIT]  = 1'b1;
    end
    // LED level as it stands after the whole tick
    for (int i = 0; i < n; i++) scan_out[i].led = led_lvl;
    if (n == 0) begin
      scan_out[0] = {led_lvl, drive, 1'b0, 5'd0, 1'b0, 1'b1};
      n = 1;
    end else begin
      scan_out[n-1].last = 1'b1;
    end
    return n;
  endfunction

  // column lines for row r: same as held, one key toggled, or anything
  function automatic logic [COL_W-1:0] next_cols(input logic [1:0] r);
    logic [COL_W-1:0] held;
    logic [COL_W-1:0] cols;
    held = keys_held[r];
    case ($urandom_range(3))
      0:       cols = held;
      3:       cols = COL_W'($urandom);
      default: cols = held ^ (5'b00001 << $urandom_range(COL_W - 1));
    endcase
    return cols;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("error at %0t: %s", $time, msg);
  endtask

  task automatic compare_result(input key_event_t got, input key_event_t want);
    if (got.led != want.led)
      report_mismatch($sformatf("result %0d led_pins got %0h want %0h",
                                results_seen, got.led, want.led));
    if (got.drive != want.drive)
      report_mismatch($sformatf("result %0d row_drive got %0h want %0h",
                                results_seen, got.drive, want.drive));
    if (got.ev != want.ev)
      report_mismatch($sformatf("result %0d event_valid got %0h want %0h",
                                results_seen, got.ev, want.ev));
    if (got.key != want.key)
      report_mismatch($sformatf("result %0d key_index got %0d want %0d",
                                results_seen, got.key, want.key));
    if (got.pressed != want.pressed)
      report_mismatch($sformatf("result %0d key_pressed got %0h want %0h",
                                results_seen, got.pressed, want.pressed));
    if (got.last != want.last)
      report_mismatch($sformatf("result %0d last got %0h want %0h",
                                results_seen, got.last, want.last));
  endtask

  // offer one item from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input item_kind_t kind, input logic [COL_W-1:0] cols,
                           input bit typed, input key_event_t want);
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid         = 1'b1;
    sample_ch.kind          = kind;
    sample_ch.column_sample = cols;
    typed_on                = typed;
    typed_want              = want;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // ticks up to the count just before the wrap
  task automatic tick_to_wrap();
    while (pwm_cnt != 8'hFF) send_item(KIND_TICK, COL_W'($urandom), 1'b0, '0);
  endtask

  task automatic wait_quiet();
    sample_ch.valid = 1'b0;
    @(negedge clk);
    while (key_events_due.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [DUTY_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = !(rcv_pct != 0 && $urandom_range(99) < rcv_pct);
      end
    end
  end

  // monitor: duty writes, result checks, item predictions, stall count
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_reg_t'(cfg_ch.index))
          REG_RED:   red_at   = cfg_ch.data;
          REG_GREEN: green_at = cfg_ch.data;
          REG_BLUE:  blue_at  = cfg_ch.data;
          default: ;
        endcase
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        got_event = {result_ch.led_pins, result_ch.row_drive, result_ch.event_valid,
                     result_ch.key_index, result_ch.key_pressed, result_ch.last};
        if (key_events_due.size() == 0) begin
          report_mismatch($sformatf("result %0d not expected: %0h", results_seen, got_event));
        end else begin
          want_event = key_events_due.pop_front();
          compare_result(got_event, want_event);
        end
        results_seen++;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        moved = 1'b1;
        scan_count = scan_keypad(item_kind_t'(sample_ch.kind), sample_ch.column_sample);
        if (typed_on) begin
          key_events_due.push_back(typed_want);
        end else begin
          for (int i = 0; i < scan_count; i++) key_events_due.push_back(scan_out[i]);
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("keypad_scan_with_led_pwm: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    logic [DUTY_W-1:0] red_set;
    logic [DUTY_W-1:0] green_set;
    logic [DUTY_W-1:0] blue_set;
    int                pick;
    rst                     = 1'b1;
    sample_ch.valid         = 1'b0;
    sample_ch.kind          = KIND_TICK;
    sample_ch.column_sample = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = REG_RED;
    cfg_ch.data             = '0;
    typed_on                = 1'b0;
    typed_want              = '0;
    snd_pct                 = 0;
    rcv_pct                 = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at reset duties
    foreach (directed_rows[i]) begin
      if (directed_rows[i].to_wrap) tick_to_wrap();
      send_item(directed_rows[i].kind, directed_rows[i].cols,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each with its own duties and idling
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      snd_pct = SEND_IDLE[p];
      rcv_pct = RECV_STALL[p];
      red_set   = DUTY_W'($urandom);
      green_set = DUTY_W'($urandom);
      blue_set  = DUTY_W'($urandom);
      case (p)
        0: begin red_set = 8'd255; green_set = 8'd128; blue_set = 8'd0;   end
        1: begin red_set = 8'd0;   green_set = 8'd255; blue_set = 8'd255; end
        3: begin red_set = 8'd1;   green_set = 8'd254; blue_set = 8'd0;   end
        default: ;
      endcase
      cfg_write(REG_RED, red_set);
      cfg_write(REG_GREEN, green_set);
      cfg_write(REG_BLUE, blue_set);
      cfg_ch.valid = 1'b0;
      for (int s = 0; s < STEPS; s++) begin
        // long result hold-off while items keep coming
        if (p == 4 && s == 1) hold_req = 1'b1;
        // sender pause until every result is in
        if (p == 1 && s == 3) wait_quiet();
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_item(KIND_TICK, COL_W'($urandom), 1'b0, '0);
        end else begin
          send_item(KIND_PIN, next_cols(cur_row), 1'b0, '0);
        end
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("keypad_scan_with_led_pwm: match");
    end else begin
      $display("keypad_scan_with_led_pwm: mismatch");
    end
    $finish;
  end

endmodule
